// File: rtl/dpad_socd_cleaner_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the SOCD cleaner core
// Clocked implication checks, gated off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef DPAD_SOCD_CLEANER_CORE_ASSERT_SVH
`define DPAD_SOCD_CLEANER_CORE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsc assertion failed");

// Next-cycle implication: cons must follow ante.
`define DSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsc assertion failed");

`endif

// File: rtl/dsc_pkg.sv
// ---------------------------------------------------------------------------
// dsc_pkg
// Shared types, codes and the per-axis last-wins resolution function.
// ---------------------------------------------------------------------------
package dsc_pkg;

    localparam int DSC_PAD_SLOTS    = 8;
    localparam int WORD_W           = 32;
    localparam int PLAYER_W         = 8;
    localparam int BITPOS_W         = 5;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 5;

    typedef enum logic [1:0] {
        MODE_PASS      = 2'd0,
        MODE_NEUTRAL   = 2'd1,
        MODE_UP_PRIO   = 2'd2,
        MODE_LAST_WINS = 2'd3
    } pad_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_UP    = 3'd1,
        REG_DOWN  = 3'd2,
        REG_LEFT  = 3'd3,
        REG_RIGHT = 3'd4
    } reg_idx_t;

    // Winner codes of one axis
    localparam logic [1:0] WIN_NONE = 2'd0;
    localparam logic [1:0] WIN_A    = 2'd1;
    localparam logic [1:0] WIN_B    = 2'd2;

    typedef struct packed {
        pad_mode_t             mode;
        logic [BITPOS_W-1:0]   up_bit;
        logic [BITPOS_W-1:0]   down_bit;
        logic [BITPOS_W-1:0]   left_bit;
        logic [BITPOS_W-1:0]   right_bit;
    } cfg_t;

    // Per-player axis memory, bit 0 at the bottom
    typedef struct packed {
        logic       r_prev;
        logic       l_prev;
        logic       d_prev;
        logic       u_prev;
        logic [1:0] lr_win;
        logic [1:0] ud_win;
    } axis_mem_t;

    typedef struct packed {
        logic [1:0] win;
        logic       clr_a;
        logic       clr_b;
    } axis_res_t;

    function automatic axis_res_t last_wins_axis(
        input logic       a,
        input logic       b,
        input logic       a_prev,
        input logic       b_prev,
        input logic [1:0] win_in
    );
        axis_res_t res;
        res = '0;
        if (a && b)
        begin
            res.win = win_in;
            if (!a_prev)
            begin
                res.win = WIN_A;
            end
            if (!b_prev)
            begin
                res.win = WIN_B;
            end
            res.clr_b = (res.win == WIN_A);
            res.clr_a = (res.win == WIN_B);
        end
        else if (a)
        begin
            res.win = WIN_A;
        end
        else if (b)
        begin
            res.win = WIN_B;
        end
        else
        begin
            res.win = WIN_NONE;
        end
        return res;
    endfunction

endpackage

// File: rtl/dpad_socd_cleaner_core.sv
// ---------------------------------------------------------------------------
// dpad_socd_cleaner_core
// SOCD cleaner: resolves opposite D-pad presses in a 32-bit button word.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, button_word, player) carries one frame
//   per transfer; output channel (out_valid/out_ready, cleaned_word) returns
//   exactly one cleaned word per input transfer, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 mode, 1..4 up/down/left/right bit positions. Write it
//   only while no frame is in flight.
// Pipeline and throughput:
//   A frame passes a two-register path: the input stage with the player
//   memory read, then the result register. One frame per cycle is
//   sustained while out_ready stays high, including back-to-back frames
//   of the same player, which the memory forwards.
// Reset:
//   Mode goes to passthrough, bit positions to 0/1/2/3, every player's axis
//   memory reads as zero (per-entry valid bits), both stages empty.
// Stall:
//   When out_ready is low the result holds; the input stage still takes one
//   more frame, then in_ready drops until the result register drains.
// ---------------------------------------------------------------------------
module dpad_socd_cleaner_core
    import dsc_pkg::*;
#(
    parameter int PAD_SLOTS = DSC_PAD_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_W-1:0]     button_word,
    input  logic [PLAYER_W-1:0]   player,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_W-1:0]     cleaned_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int              IDX_W        = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;
    localparam logic [PLAYER_W-1:0] PLAYER_LIMIT = PLAYER_W'(PAD_SLOTS);

    cfg_t               cfg;
    axis_mem_t          mem_rd;
    axis_mem_t          mem_wr;
    logic               wr_en;
    logic [WORD_W-1:0]  cleaned;

    logic               s1_valid_reg;
    logic [WORD_W-1:0]  s1_word_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_in_range_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  cleaned_word_reg;

    logic               in_accept;
    logic               s1_advance;

    // Config port: always ready, writes land the same edge
    assign cfg_ready = 1'b1;

    dsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_idx  (cfg_index),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    // Advance the input stage when the result register is free or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // Player memory is read on the input transfer, written as the frame
    // leaves the input stage
    dsc_state_mem #(
        .PAD_SLOTS (PAD_SLOTS)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_idx  (player[IDX_W-1:0]),
        .wr_en   (wr_en && s1_advance),
        .wr_idx  (s1_idx_reg),
        .wr_data (mem_wr),
        .rd_data (mem_rd)
    );

    dsc_resolve u_resolve (
        .cfg      (cfg),
        .word     (s1_word_reg),
        .in_range (s1_in_range_reg),
        .mem_in   (mem_rd),
        .cleaned  (cleaned),
        .wr_en    (wr_en),
        .mem_out  (mem_wr)
    );

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input stage payload: hold until the next transfer
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg     <= button_word;
            s1_idx_reg      <= player[IDX_W-1:0];
            s1_in_range_reg <= (player < PLAYER_LIMIT);
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            cleaned_word_reg <= cleaned;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cleaned_word = cleaned_word_reg;

`include "dpad_socd_cleaner_core_assert.svh"

    // Full input stage behind a stalled result must refuse new frames
    `DSC_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, s1_valid_reg && out_valid_reg && !out_ready, !in_ready)
    // Cleaning only ever drops bits
    `DSC_ASSERT_NEXT(a_no_new_bits, clk, rst_n, s1_advance, (cleaned_word_reg & ~$past(s1_word_reg)) == '0)
    // Out-of-range player passes the word unchanged
    `DSC_ASSERT_NEXT(a_out_of_range_pass, clk, rst_n, s1_advance && !s1_in_range_reg, cleaned_word_reg == $past(s1_word_reg))
    // Passthrough mode leaves the word unchanged
    `DSC_ASSERT_NEXT(a_passthrough, clk, rst_n, s1_advance && (cfg.mode == MODE_PASS), cleaned_word_reg == $past(s1_word_reg))

endmodule

// File: rtl/dsc_cfg.sv
// ---------------------------------------------------------------------------
// dsc_cfg
// Configuration register file: mode and the four D-pad bit positions.
// ---------------------------------------------------------------------------
module dsc_cfg
    import dsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_idx,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_PASS;
            cfg_reg.up_bit    <= 5'd0;
            cfg_reg.down_bit  <= 5'd1;
            cfg_reg.left_bit  <= 5'd2;
            cfg_reg.right_bit <= 5'd3;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_MODE:  cfg_reg.mode      <= pad_mode_t'(wr_data[1:0]);
                REG_UP:    cfg_reg.up_bit    <= wr_data[BITPOS_W-1:0];
                REG_DOWN:  cfg_reg.down_bit  <= wr_data[BITPOS_W-1:0];
                REG_LEFT:  cfg_reg.left_bit  <= wr_data[BITPOS_W-1:0];
                REG_RIGHT: cfg_reg.right_bit <= wr_data[BITPOS_W-1:0];
                default:   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/dsc_state_mem.sv
// ---------------------------------------------------------------------------
// dsc_state_mem
// Per-player axis memory with valid bits and write-to-read forwarding.
// ---------------------------------------------------------------------------
module dsc_state_mem
    import dsc_pkg::*;
#(
    parameter int  PAD_SLOTS = DSC_PAD_SLOTS,
    localparam int IDX_W     = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_idx,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  axis_mem_t           wr_data,
    output axis_mem_t           rd_data
);

    axis_mem_t                 mem [PAD_SLOTS];
    axis_mem_t                 mem_q_reg;
    axis_mem_t                 fwd_data_reg;
    logic [PAD_SLOTS-1:0]      valid_reg;
    logic                      hit_reg;
    logic                      fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_idx];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_idx];
                fwd_reg <= wr_en && (wr_idx == rd_idx);
            end
        end
    end

    // Unwritten entries read as the reset value (all zero)
    assign rd_data = fwd_reg ? fwd_data_reg : (hit_reg ? mem_q_reg : axis_mem_t'('0));

endmodule

// File: rtl/dsc_resolve.sv
// ---------------------------------------------------------------------------
// dsc_resolve
// Opposite-direction resolution of one button word for the active mode.
// ---------------------------------------------------------------------------
module dsc_resolve
    import dsc_pkg::*;
(
    input  cfg_t                cfg,
    input  logic [WORD_W-1:0]   word,
    input  logic                in_range,
    input  axis_mem_t           mem_in,
    output logic [WORD_W-1:0]   cleaned,
    output logic                wr_en,
    output axis_mem_t           mem_out
);

    logic [WORD_W-1:0] mu;
    logic [WORD_W-1:0] md;
    logic [WORD_W-1:0] ml;
    logic [WORD_W-1:0] mr;
    logic [WORD_W-1:0] clr;
    logic              u;
    logic              d;
    logic              l;
    logic              r;
    axis_res_t         ud_res;
    axis_res_t         lr_res;

    assign mu = WORD_W'(1) << cfg.up_bit;
    assign md = WORD_W'(1) << cfg.down_bit;
    assign ml = WORD_W'(1) << cfg.left_bit;
    assign mr = WORD_W'(1) << cfg.right_bit;

    assign u = |(word & mu);
    assign d = |(word & md);
    assign l = |(word & ml);
    assign r = |(word & mr);

    assign ud_res = last_wins_axis(u, d, mem_in.u_prev, mem_in.d_prev, mem_in.ud_win);
    assign lr_res = last_wins_axis(l, r, mem_in.l_prev, mem_in.r_prev, mem_in.lr_win);

    always_comb
    begin
        clr = '0;
        if (in_range)
        begin
            unique case (cfg.mode)
                MODE_PASS:
                begin
                    clr = '0;
                end
                MODE_NEUTRAL:
                begin
                    if (u && d)
                    begin
                        clr = clr | mu | md;
                    end
                    if (l && r)
                    begin
                        clr = clr | ml | mr;
                    end
                end
                MODE_UP_PRIO:
                begin
                    if (u && d)
                    begin
                        clr = clr | md;
                    end
                    if (l && r)
                    begin
                        clr = clr | ml | mr;
                    end
                end
                MODE_LAST_WINS:
                begin
                    clr = ({WORD_W{ud_res.clr_a}} & mu) | ({WORD_W{ud_res.clr_b}} & md)
                        | ({WORD_W{lr_res.clr_a}} & ml) | ({WORD_W{lr_res.clr_b}} & mr);
                end
                default:
                begin
                    clr = '0;
                end
            endcase
        end
    end

    assign cleaned = word & ~clr;

    // Only last-wins mode updates the player's memory
    assign wr_en = in_range && (cfg.mode == MODE_LAST_WINS);

    always_comb
    begin
        mem_out.ud_win = ud_res.win;
        mem_out.lr_win = lr_res.win;
        mem_out.u_prev = u;
        mem_out.d_prev = d;
        mem_out.l_prev = l;
        mem_out.r_prev = r;
    end

endmodule
